@@ rtl/core/jsesc_pkg.sv @@
// Shared types, character codes and byte classification for the JSON string escaper.
// Used by jsesc_front, jsesc_drain and json_string_escaper_utf8_core.
package jsesc_pkg;

    typedef logic [7:0] t_byte;

    // One escaped unit: up to six bytes, element 0 goes out first
    typedef struct packed {
        logic [2:0]      len;
        logic [5:0][7:0] bytes;
    } t_unit;

    // Work handed from the front end to the output drain for one input word
    typedef struct packed {
        logic [2:0]      reps;      // U+FFFD groups sent first
        logic [2:0]      main_len;  // bytes of the main unit after them
        logic [5:0][7:0] main;
        logic [3:0]      total;     // all bytes of the run, dots included
        logic            done;      // final byte closes the string
    } t_run;

    localparam int    LIMIT_W     = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd99996;

    localparam logic  CFG_LOWERCASE = 1'b0;
    localparam logic  CFG_LIMIT     = 1'b1;

    localparam t_byte REPL_0   = 8'hEF;
    localparam t_byte REPL_1   = 8'hBF;
    localparam t_byte REPL_2   = 8'hBD;
    localparam t_byte CH_DOT   = 8'h2E;
    localparam t_byte CH_BSL   = 8'h5C;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_BS    = 8'h08;
    localparam t_byte CH_FF    = 8'h0C;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_LC_B  = 8'h62;
    localparam t_byte CH_LC_F  = 8'h66;
    localparam t_byte CH_LC_N  = 8'h6E;
    localparam t_byte CH_LC_R  = 8'h72;
    localparam t_byte CH_LC_T  = 8'h74;
    localparam t_byte CH_LC_U  = 8'h75;

    // Full sequence length for a lead byte, zero when it cannot lead one
    function automatic logic [2:0] lead_need(input t_byte b);
        logic [2:0] n;
        case (b) inside
            [8'hC2:8'hDF]: n = 3'd2;
            [8'hE0:8'hEF]: n = 3'd3;
            [8'hF0:8'hF4]: n = 3'd4;
            default:       n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_byte second_lo(input t_byte b);
        t_byte v;
        case (b)
            8'hE0:   v = 8'hA0;
            8'hF0:   v = 8'h90;
            default: v = 8'h80;
        endcase
        return v;
    endfunction

    function automatic t_byte second_hi(input t_byte b);
        t_byte v;
        case (b)
            8'hED:   v = 8'h9F;
            8'hF4:   v = 8'h8F;
            default: v = 8'hBF;
        endcase
        return v;
    endfunction

    function automatic t_byte hex_digit(input logic [3:0] n);
        t_byte v;
        if (n < 4'd10) v = CH_ZERO + {4'h0, n};
        else           v = 8'h57 + {4'h0, n};
        return v;
    endfunction

    // Unit for a byte seen with nothing held; a valid lead byte gives length zero
    function automatic t_unit fresh_unit(input t_byte b, input logic lower);
        t_unit u;
        u.len   = 3'd0;
        u.bytes = '0;
        if (!b[7]) begin
            u.bytes[0] = CH_BSL;
            u.len      = 3'd2;
            case (b)
                CH_BSL:   u.bytes[1] = CH_BSL;
                CH_QUOTE: u.bytes[1] = CH_QUOTE;
                CH_BS:    u.bytes[1] = CH_LC_B;
                CH_FF:    u.bytes[1] = CH_LC_F;
                CH_LF:    u.bytes[1] = CH_LC_N;
                CH_CR:    u.bytes[1] = CH_LC_R;
                CH_TAB:   u.bytes[1] = CH_LC_T;
                default: begin
                    if (b < 8'h20) begin
                        u.bytes[1] = CH_LC_U;
                        u.bytes[2] = CH_ZERO;
                        u.bytes[3] = CH_ZERO;
                        u.bytes[4] = hex_digit(b[7:4]);
                        u.bytes[5] = hex_digit(b[3:0]);
                        u.len      = 3'd6;
                    end else begin
                        if (lower && (b inside {[8'h41:8'h5A]})) u.bytes[0] = b | 8'h20;
                        else                                     u.bytes[0] = b;
                        u.len = 3'd1;
                    end
                end
            endcase
        end else if (lead_need(b) == 3'd0) begin
            u.bytes[0] = REPL_0;
            u.bytes[1] = REPL_1;
            u.bytes[2] = REPL_2;
            u.len      = 3'd3;
        end
        return u;
    endfunction

endpackage

@@ rtl/core/jsesc_front.sv @@
// Front end: configuration registers, UTF-8 hold state and per-word decode.
// Turns each accepted input word into at most one run for jsesc_drain; needs jsesc_pkg.
module jsesc_front
    import jsesc_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    input  logic               i_load_ok,
    output logic               o_in_ready,
    output logic               o_run_load,
    output t_run               o_run
);

    localparam int SW = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 1;

    logic                   r_lower;
    logic [LIMIT_W-1:0]     r_limit;
    t_byte                  r_pend [0:2];
    logic [1:0]             r_pcount;
    logic                   r_trunc;
    logic [COUNT_WIDTH-1:0] r_emit;

    logic       accept;
    t_unit      fresh;
    logic       fresh_lead;
    logic [2:0] need_p;
    t_byte      lo;
    t_byte      hi;
    logic       ok;
    logic [2:0] reps;
    t_unit      main;
    logic [1:0] keep;
    logic       st_en;
    logic [1:0] st_idx;
    logic [SW-1:0] e_ext;
    logic [SW-1:0] lim_ext;
    logic [3:0] fit;
    logic       fit_reps;
    logic       fit_main;
    logic [3:0] step_len;
    logic [2:0] rep_out;
    logic       halt;
    logic [2:0] main_out;

    assign accept     = i_in_valid && i_load_ok;
    assign o_in_ready = i_load_ok;

    assign fresh      = fresh_unit(i_in_byte, r_lower);
    assign fresh_lead = i_in_byte[7] && (lead_need(i_in_byte) != 3'd0);
    assign need_p     = lead_need(r_pend[0]);
    assign lo         = (r_pcount == 2'd1) ? second_lo(r_pend[0]) : 8'h80;
    assign hi         = (r_pcount == 2'd1) ? second_hi(r_pend[0]) : 8'hBF;
    assign ok         = (need_p >= 3'd2) && ({1'b0, r_pcount} < need_p)
                        && (i_in_byte >= lo) && (i_in_byte <= hi);

    always_comb begin
        reps   = 3'd0;
        main   = fresh;
        keep   = 2'd0;
        st_en  = 1'b0;
        st_idx = 2'd0;
        if (r_pcount == 2'd0 || !ok) begin
            // a broken sequence flushes every held byte, then the word starts afresh
            if (r_pcount != 2'd0) reps = {1'b0, r_pcount};
            if (fresh_lead) begin
                keep  = 2'd1;
                st_en = 1'b1;
            end
        end else if ({1'b0, r_pcount} + 3'd1 == need_p) begin
            main.len      = need_p;
            main.bytes    = '0;
            main.bytes[0] = r_pend[0];
            main.bytes[1] = r_pend[1];
            main.bytes[2] = r_pend[2];
            main.bytes[{1'b0, r_pcount}] = i_in_byte;
        end else begin
            main.len = 3'd0;
            st_en    = 1'b1;
            st_idx   = r_pcount;
            keep     = r_pcount + 2'd1;
        end
        // the string ends with bytes still held: each becomes a replacement
        if (i_in_last && keep != 2'd0) begin
            reps = reps + {1'b0, keep};
            keep = 2'd0;
        end
    end

    assign e_ext    = SW'(r_emit);
    assign lim_ext  = SW'(r_limit);
    assign step_len = {1'b0, reps} + {reps, 1'b0} + {1'b0, main.len};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            fit[k] = (e_ext + SW'(3 * (k + 1))) <= lim_ext;
        end
    end

    assign fit_main = (e_ext + SW'(step_len)) <= lim_ext;
    assign fit_reps = (reps == 3'd0) || fit[2'(reps - 3'd1)];

    always_comb begin
        rep_out = 3'd0;
        for (int k = 0; k < 4; k++) begin
            if ((3'(k) < reps) && fit[k]) rep_out = rep_out + 3'd1;
        end
    end

    assign halt     = !fit_reps || ((main.len != 3'd0) && !fit_main);
    assign main_out = halt ? 3'd0 : main.len;

    always_comb begin
        o_run.reps     = rep_out;
        o_run.main_len = main_out;
        o_run.main     = main.bytes;
        o_run.total    = {1'b0, rep_out} + {rep_out, 1'b0} + {1'b0, main_out}
                         + (halt ? 4'd3 : 4'd0);
        o_run.done     = i_in_last || halt;
    end

    assign o_run_load = accept && !r_trunc && (o_run.total != 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWERCASE: r_lower <= i_cfg_data[0];
                CFG_LIMIT:     r_limit <= i_cfg_data;
                default:       r_lower <= r_lower;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_trunc  <= 1'b0;
            r_emit   <= '0;
        end else if (accept) begin
            if (i_in_last) begin
                r_pcount <= 2'd0;
                r_trunc  <= 1'b0;
                r_emit   <= '0;
            end else if (r_trunc) begin
                r_trunc <= 1'b1;
            end else if (halt) begin
                // drop the rest of the string until its last word
                r_trunc  <= 1'b1;
                r_pcount <= 2'd0;
            end else begin
                r_pcount <= keep;
                r_emit   <= r_emit + COUNT_WIDTH'(step_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_trunc && st_en) r_pend[st_idx] <= i_in_byte;
    end

endmodule

@@ rtl/core/jsesc_drain.sv @@
// Output drain: run buffer and output register, one escaped byte per cycle
// while the receiver is ready. Fed by jsesc_front; needs jsesc_pkg.
module jsesc_drain
    import jsesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_run_load,
    input  t_run       i_run,
    output logic       o_load_ok,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_string_done,
    input  logic       i_out_ready
);

    logic            r_run_valid;
    logic [2:0]      r_reps;
    logic [1:0]      r_phase;
    logic [5:0][7:0] r_main;
    logic [2:0]      r_main_left;
    logic [3:0]      r_left;
    logic            r_done;
    logic            r_o_valid;
    t_byte           r_o_byte;
    logic            r_o_last;
    logic            r_o_done;

    logic  out_free;
    logic  move;
    logic  final_byte;
    t_byte cur;

    assign out_free   = !r_o_valid || i_out_ready;
    assign move       = r_run_valid && out_free;
    assign final_byte = (r_left == 4'd1);
    assign o_load_ok  = !r_run_valid || (move && final_byte);

    always_comb begin
        if (r_reps != 3'd0) begin
            case (r_phase)
                2'd0:    cur = REPL_0;
                2'd1:    cur = REPL_1;
                default: cur = REPL_2;
            endcase
        end else if (r_main_left != 3'd0) begin
            cur = r_main[0];
        end else begin
            cur = CH_DOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_run_load)               r_run_valid <= 1'b1;
            else if (move && final_byte)  r_run_valid <= 1'b0;
            if (move)                     r_o_valid <= 1'b1;
            else if (i_out_ready)         r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_load) begin
            r_reps      <= i_run.reps;
            r_phase     <= 2'd0;
            r_main      <= i_run.main;
            r_main_left <= i_run.main_len;
            r_left      <= i_run.total;
            r_done      <= i_run.done;
        end else if (move) begin
            r_left <= r_left - 4'd1;
            if (r_reps != 3'd0) begin
                if (r_phase == 2'd2) begin
                    r_phase <= 2'd0;
                    r_reps  <= r_reps - 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else if (r_main_left != 3'd0) begin
                // advance to the next byte of the unit
                r_main      <= {8'h00, r_main[5:1]};
                r_main_left <= r_main_left - 3'd1;
            end
        end
        if (move) begin
            r_o_byte <= cur;
            r_o_last <= final_byte;
            r_o_done <= final_byte && r_done;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_out_byte        = r_o_byte;
    assign o_out_run_last    = r_o_last;
    assign o_out_string_done = r_o_done;

endmodule

@@ rtl/core/json_string_escaper_utf8_core.sv @@
// JSON string body escaper with UTF-8 checking: top level.
// Built from jsesc_front and jsesc_drain; needs jsesc_pkg.
//
// Input channel (i_in_valid / o_in_ready) takes one raw string byte a cycle
// with i_in_last on the final byte. Output channel (o_out_valid / i_out_ready)
// gives the escaped bytes; o_out_run_last marks the last byte caused by one
// input byte and o_out_string_done the final byte of the string, "..." ending
// a string that hit output_limit. Registers are written through i_cfg_we,
// i_cfg_index (0 lowercase_ascii, 1 output_limit) and i_cfg_data; the user
// must write them only while idle; the block does not enforce it. An input
// byte that yields n output bytes holds the run buffer until all n are sent,
// since the drain sends one byte per cycle; bytes that yield one or no output
// byte are taken every cycle. While the receiver stalls the output register
// holds its byte; one more run waits in the run buffer behind it, after which
// input stalls. Reset clears the string state, the buffers and the registers
// to their defaults (output_limit 99996); held sequence bytes are not cleared.
module json_string_escaper_utf8_core
    import jsesc_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    input  logic               i_in_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_out_run_last,
    output logic               o_out_string_done
);

    logic w_load_ok;
    logic w_run_load;
    t_run w_run;

    jsesc_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_load_ok   (w_load_ok),
        .o_in_ready  (o_in_ready),
        .o_run_load  (w_run_load),
        .o_run       (w_run)
    );

    jsesc_drain u_drain (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_run_load        (w_run_load),
        .i_run             (w_run),
        .o_load_ok         (w_load_ok),
        .o_out_valid       (o_out_valid),
        .o_out_byte        (o_out_byte),
        .o_out_run_last    (o_out_run_last),
        .o_out_string_done (o_out_string_done),
        .i_out_ready       (i_out_ready)
    );

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_string_done |-> o_out_run_last)
        else $error("string end not on the last byte of a run");

    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run_load |-> w_load_ok && (w_run.total != 4'd0))
        else $error("run loaded into a busy buffer or empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
